// ----- rtl/core/rgbft_pkg.sv -----
package rgbft_pkg;

    // Operation codes of an input request.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Transform modes.
    localparam logic [2:0] MODE_PASS   = 3'd0;
    localparam logic [2:0] MODE_NO_RED = 3'd1;
    localparam logic [2:0] MODE_NO_GRN = 3'd2;
    localparam logic [2:0] MODE_NO_BLU = 3'd3;
    localparam logic [2:0] MODE_INVERT = 3'd4;
    localparam logic [2:0] MODE_GRAY   = 3'd5;
    localparam logic [2:0] MODE_HFLIP  = 3'd6;
    localparam logic [2:0] MODE_VFLIP  = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SIZE_W     = 7;
    localparam int COORD_W    = 6;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;

    // Raster index: a 7-bit row times a 7-bit width plus a 7-bit column.
    localparam int IDX_W = 15;

    // Grayscale: floor(sum / 3) equals (sum * 683) >> 11 for any sum below 2048.
    localparam int               SUM_W     = 10;
    localparam logic [SUM_W-1:0] GRAY_MUL  = 10'd683;
    localparam int               GRAY_SHFT = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } in_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              in_range;
    } out_res_t;

    // A classified request as it travels from the front to the back.
    typedef struct packed {
        logic               operation;
        logic [2:0]         mode;
        logic               in_range;
        logic               in_store;
        logic [IDX_W-1:0]   index;
        logic [PIXEL_W-1:0] pixel;
    } cmd_t;

endpackage

// ----- rtl/core/rgb_frame_transform_store.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  in_req_t: operation, column, row, red/green/blue_in
// m_        out        m_valid / m_ready  out_res_t: red/green/blue_out, in_range
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (mode, width, height)
//
// One request is accepted per cycle while s_ready is high; its result is offered on m_valid
// after passing the front classify register, the queue, the store read stage and the
// output register. Throughput is set by the single store access, one write or one read
// each cycle while the output register is free or being taken.
// Reset is synchronous and active low; it clears control state only and the store
// holds garbage until written. A stalled m_ready fills the queue before s_ready drops.
module rgb_frame_transform_store #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rgbft_pkg::in_req_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rgbft_pkg::out_res_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [rgbft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbft_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [2:0]                   mode_reg;
    logic [rgbft_pkg::SIZE_W-1:0] width_reg;
    logic [rgbft_pkg::SIZE_W-1:0] height_reg;
    logic                         push;
    rgbft_pkg::cmd_t              push_data;
    logic                         queue_full;
    logic                         pop;
    logic                         head_valid;
    rgbft_pkg::cmd_t              head_data;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= rgbft_pkg::MODE_PASS;
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rgbft_pkg::REG_MODE:   mode_reg   <= cfg_wdata[2:0];
                rgbft_pkg::REG_WIDTH:  width_reg  <= cfg_wdata;
                rgbft_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rgbft_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .mode         (mode_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .push         (push),
        .push_data    (push_data),
        .queue_full   (queue_full)
    );

    rgbft_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    rgbft_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- rtl/core/rgbft_ram.sv -----
module rgbft_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/rgbft_front.sv -----
module rgbft_front #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rgbft_pkg::in_req_t               s_data,
    input  logic [2:0]                       mode,
    input  logic [rgbft_pkg::SIZE_W-1:0]     frame_width,
    input  logic [rgbft_pkg::SIZE_W-1:0]     frame_height,
    output logic                             push,
    output rgbft_pkg::cmd_t                  push_data,
    input  logic                             queue_full
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic                         valid_reg;
    logic                         valid_next;
    rgbft_pkg::cmd_t              cmd_reg;
    rgbft_pkg::cmd_t              cmd_next;
    logic [rgbft_pkg::SIZE_W-1:0] w_used;
    logic [rgbft_pkg::SIZE_W-1:0] h_used;
    logic [rgbft_pkg::SIZE_W-1:0] col_ext;
    logic [rgbft_pkg::SIZE_W-1:0] row_ext;
    logic [rgbft_pkg::SIZE_W-1:0] sel_col;
    logic [rgbft_pkg::SIZE_W-1:0] sel_row;
    logic [rgbft_pkg::IDX_W-1:0]  index;
    logic                         accept;

    // Sizes above the store's maximum are clamped to it.
    assign w_used = (32'(frame_width) > MAX_WIDTH) ? rgbft_pkg::SIZE_W'(MAX_WIDTH)
                                                   : frame_width;
    assign h_used = (32'(frame_height) > MAX_HEIGHT) ? rgbft_pkg::SIZE_W'(MAX_HEIGHT)
                                                     : frame_height;
    assign col_ext = rgbft_pkg::SIZE_W'(s_data.column);
    assign row_ext = rgbft_pkg::SIZE_W'(s_data.row);

    // Mirrored reads fetch from the opposite column or row.
    always_comb begin
        sel_col = col_ext;
        sel_row = row_ext;
        if (s_data.operation == rgbft_pkg::OP_READ) begin
            if (mode == rgbft_pkg::MODE_HFLIP) begin
                sel_col = w_used - 7'd1 - col_ext;
            end else if (mode == rgbft_pkg::MODE_VFLIP) begin
                sel_row = h_used - 7'd1 - row_ext;
            end
        end
    end

    assign index = rgbft_pkg::IDX_W'(sel_row) * rgbft_pkg::IDX_W'(w_used)
                 + rgbft_pkg::IDX_W'(sel_col);

    // Classification of the incoming request.
    always_comb begin
        cmd_next.operation = s_data.operation;
        cmd_next.mode      = mode;
        cmd_next.in_range  = (col_ext < w_used) && (row_ext < h_used);
        cmd_next.in_store  = 32'(index) < DEPTH;
        cmd_next.index     = index;
        cmd_next.pixel     = {s_data.red_in, s_data.green_in, s_data.blue_in};
    end

    assign push    = valid_reg && !queue_full;
    assign s_ready = !valid_reg || !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

    assign push_data = cmd_reg;

endmodule

// ----- rtl/core/rgbft_queue.sv -----
module rgbft_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rgbft_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rgbft_pkg::cmd_t head_data
);

    localparam int CNT_W = rgbft_pkg::QPTR_W + 1;

    rgbft_pkg::cmd_t              entry_reg [rgbft_pkg::QUEUE_DEPTH];
    logic [rgbft_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [rgbft_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full       = count_reg == CNT_W'(rgbft_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + rgbft_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + rgbft_pkg::QPTR_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/rgbft_back.sv -----
module rgbft_back #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  rgbft_pkg::cmd_t     head_data,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output rgbft_pkg::out_res_t m_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = rgbft_pkg::CHAN_W;
    localparam int PW    = rgbft_pkg::PIXEL_W;
    localparam int SW    = rgbft_pkg::SUM_W;
    localparam int PROD_W = 2 * SW;

    logic                advance;
    logic                wr_en;
    logic                rd_en;
    logic [AW-1:0]       addr;
    logic [PW-1:0]       rd_data;
    logic                s1_valid_reg;
    rgbft_pkg::cmd_t     s1_cmd_reg;
    logic                m_valid_reg;
    rgbft_pkg::out_res_t m_data_reg;
    rgbft_pkg::out_res_t m_data_next;
    logic [PW-1:0]       pixel;
    logic [CW-1:0]       red;
    logic [CW-1:0]       green;
    logic [CW-1:0]       blue;
    logic [SW-1:0]       sum;
    logic [PROD_W-1:0]   prod;
    logic [CW-1:0]       gray;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance = !m_valid_reg || m_ready;
    assign pop     = head_valid && advance;
    assign addr    = AW'(head_data.index);
    assign wr_en   = pop && (head_data.operation == rgbft_pkg::OP_WRITE)
                     && head_data.in_range && head_data.in_store;
    assign rd_en   = pop && (head_data.operation == rgbft_pkg::OP_READ);

    rgbft_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (head_data.pixel),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Fetched pixel; an index past the store reads as black.
    assign pixel = s1_cmd_reg.in_store ? rd_data : '0;
    assign red   = pixel[PW-1 -: CW];
    assign green = pixel[2*CW-1 -: CW];
    assign blue  = pixel[CW-1:0];
    assign sum   = SW'(red) + SW'(green) + SW'(blue);
    assign prod  = PROD_W'(sum) * PROD_W'(rgbft_pkg::GRAY_MUL);
    assign gray  = prod[rgbft_pkg::GRAY_SHFT +: CW];

    // Transform applied to a read; writes and out-of-range reads give zeros.
    always_comb begin
        m_data_next.red_out   = '0;
        m_data_next.green_out = '0;
        m_data_next.blue_out  = '0;
        m_data_next.in_range  = s1_cmd_reg.in_range;
        if (s1_cmd_reg.operation == rgbft_pkg::OP_READ && s1_cmd_reg.in_range) begin
            m_data_next.red_out   = red;
            m_data_next.green_out = green;
            m_data_next.blue_out  = blue;
            unique case (s1_cmd_reg.mode)
                rgbft_pkg::MODE_PASS, rgbft_pkg::MODE_HFLIP, rgbft_pkg::MODE_VFLIP: begin
                end
                rgbft_pkg::MODE_NO_RED: begin
                    m_data_next.red_out = '0;
                end
                rgbft_pkg::MODE_NO_GRN: begin
                    m_data_next.green_out = '0;
                end
                rgbft_pkg::MODE_NO_BLU: begin
                    m_data_next.blue_out = '0;
                end
                rgbft_pkg::MODE_INVERT: begin
                    m_data_next.red_out   = ~red;
                    m_data_next.green_out = ~green;
                    m_data_next.blue_out  = ~blue;
                end
                rgbft_pkg::MODE_GRAY: begin
                    m_data_next.red_out   = gray;
                    m_data_next.green_out = gray;
                    m_data_next.blue_out  = gray;
                end
            endcase
        end
    end

    // Valid flags of the fetch stage and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= pop;
            m_valid_reg  <= s1_valid_reg;
        end
    end

    // Payloads.
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_cmd_reg <= head_data;
        end
        if (advance && s1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
